>>> rtl/core/vrl_pkg.sv
// Shared types and constants for the three-axis velocity ramp limiter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vrl_pkg;

   localparam int SPEED_WIDTH_DEF = 16;
   localparam int STEP_WIDTH      = 15;
   localparam int RATIO_WIDTH     = 17;
   localparam int RATIO_FRAC      = 16;
   localparam logic [RATIO_WIDTH-1:0] RATIO_ONE = 17'h10000;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      REQ_COMMAND = 2'd0,
      REQ_LOAD    = 2'd1,
      REQ_STOP    = 2'd2,
      REQ_RELEASE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_STEP_X     = 3'd0,
      REG_STEP_Y     = 3'd1,
      REG_STEP_Z     = 3'd2,
      REG_SOFT_EN    = 3'd3,
      REG_SOFT_RATIO = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [STEP_WIDTH-1:0]  step_x;
      logic [STEP_WIDTH-1:0]  step_y;
      logic [STEP_WIDTH-1:0]  step_z;
      logic                   soft_en;
      logic [RATIO_WIDTH-1:0] soft_ratio;
      logic [RATIO_WIDTH-1:0] ratio_eff;
   } cfg_type;

endpackage

>>> rtl/core/vrl_csr.sv
// Configuration registers of the velocity ramp limiter behind an APB-style port.
// Depends on vrl_pkg for the register map and the cfg_type bundle.
`timescale 1ns / 1ps

module vrl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vrl_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [vrl_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [vrl_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output vrl_pkg::cfg_type                    cfg
);
   import vrl_pkg::*;

   logic [STEP_WIDTH-1:0]  step_x_ff, step_y_ff, step_z_ff;
   logic                   soft_en_ff;
   logic [RATIO_WIDTH-1:0] soft_ratio_ff;
   logic                   wr_en;
   csr_reg_type            reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_x_ff     <= '0;
         step_y_ff     <= '0;
         step_z_ff     <= '0;
         soft_en_ff    <= 1'b0;
         soft_ratio_ff <= RATIO_ONE;
      end else if (wr_en) begin
         case (reg_sel)
            REG_STEP_X:     step_x_ff     <= csr_pwdata[STEP_WIDTH-1:0];
            REG_STEP_Y:     step_y_ff     <= csr_pwdata[STEP_WIDTH-1:0];
            REG_STEP_Z:     step_z_ff     <= csr_pwdata[STEP_WIDTH-1:0];
            REG_SOFT_EN:    soft_en_ff    <= csr_pwdata[0];
            REG_SOFT_RATIO: soft_ratio_ff <= csr_pwdata[RATIO_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_STEP_X:     csr_prdata = CSR_DATA_WIDTH'(step_x_ff);
         REG_STEP_Y:     csr_prdata = CSR_DATA_WIDTH'(step_y_ff);
         REG_STEP_Z:     csr_prdata = CSR_DATA_WIDTH'(step_z_ff);
         REG_SOFT_EN:    csr_prdata = CSR_DATA_WIDTH'(soft_en_ff);
         REG_SOFT_RATIO: csr_prdata = CSR_DATA_WIDTH'(soft_ratio_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.step_x     = step_x_ff;
      cfg.step_y     = step_y_ff;
      cfg.step_z     = step_z_ff;
      cfg.soft_en    = soft_en_ff;
      cfg.soft_ratio = soft_ratio_ff;
      // zero or anything above 1.0 behaves as unity
      if (soft_ratio_ff == '0 || soft_ratio_ff > RATIO_ONE) begin
         cfg.ratio_eff = RATIO_ONE;
      end else begin
         cfg.ratio_eff = soft_ratio_ff;
      end
   end

endmodule

>>> rtl/core/vrl_axis.sv
// One axis of the ramp datapath: optional clamp to +/-1.0, one step toward
// the target, optional soft-stop scaling. Depends on vrl_pkg.
`timescale 1ns / 1ps

module vrl_axis #(
   parameter int W        = vrl_pkg::SPEED_WIDTH_DEF,
   parameter bit CLAMP_EN = 1'b1
) (
   input  logic signed [W-1:0]                cur,
   input  logic signed [W-1:0]                target,
   input  logic [vrl_pkg::STEP_WIDTH-1:0]     step,
   input  logic                               soft_en,
   input  logic [vrl_pkg::RATIO_WIDTH-1:0]    ratio,
   output logic signed [W-1:0]                next
);
   import vrl_pkg::*;

   localparam int CW = ((W > STEP_WIDTH) ? W : STEP_WIDTH) + 2;
   localparam int PW = W + RATIO_WIDTH;
   localparam logic signed [W-1:0] ONE_Q   = (W)'(64'sd1 <<< (W - 4));
   localparam logic signed [W-1:0] NEG_ONE = -ONE_Q;

   logic signed [W-1:0]  clamped;
   logic signed [CW-1:0] cur_x, tgt_x, step_x, diff, mag, ramp_x;
   logic signed [W-1:0]  ramped;
   logic                 neg;
   logic [W-1:0]         mag_r;
   logic [PW-1:0]        prod;
   logic [W-1:0]         prod_top;
   logic signed [W-1:0]  scaled;

   always_comb begin
      clamped = cur;
      if (CLAMP_EN) begin
         if (cur > ONE_Q) begin
            clamped = ONE_Q;
         end else if (cur < NEG_ONE) begin
            clamped = NEG_ONE;
         end
      end
   end

   assign cur_x  = CW'(clamped);
   assign tgt_x  = CW'(target);
   assign step_x = CW'($signed({1'b0, step}));
   assign diff   = tgt_x - cur_x;
   assign mag    = diff[CW-1] ? -diff : diff;

   // snap to the target when within one step, else move exactly one step
   always_comb begin
      if (mag < step_x) begin
         ramp_x = tgt_x;
      end else if (diff[CW-1]) begin
         ramp_x = cur_x - step_x;
      end else begin
         ramp_x = cur_x + step_x;
      end
   end

   assign ramped = ramp_x[W-1:0];

   // scale the magnitude so the product truncates toward zero
   assign neg      = ramped[W-1];
   assign mag_r    = neg ? W'(-ramped) : W'(ramped);
   assign prod     = PW'(mag_r) * PW'(ratio);
   assign prod_top = prod[W+RATIO_FRAC-1:RATIO_FRAC];
   assign scaled   = neg ? -$signed(prod_top) : $signed(prod_top);

   assign next = soft_en ? scaled : ramped;

endmodule

>>> rtl/core/three_axis_velocity_ramp_limiter.sv
// Three-axis velocity ramp limiter: input register, per-axis ramp logic,
// speed/result register. Depends on vrl_pkg, vrl_csr and vrl_axis.
// Path: a request transaction enters the input register, then the speed register raises response valid.
// Throughput: one transaction per cycle while the response side is not stalled by rsp_tready.
// Reset: synchronous; speeds zero, stop released, steps 0, soft stop off, ratio 1.0.
`timescale 1ns / 1ps

module three_axis_velocity_ramp_limiter #(
   parameter int SPEED_WIDTH = vrl_pkg::SPEED_WIDTH_DEF,
   localparam int TDATA_WIDTH = ((3 * SPEED_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: target_linear_x, target_linear_y, target_angular_z
   input  logic [TDATA_WIDTH-1:0]             req_tdata,
   // req_tuser: req_type
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // rsp_tdata: speed_linear_x, speed_linear_y, speed_angular_z
   output logic [TDATA_WIDTH-1:0]             rsp_tdata,
   // rsp_tuser: stop_latched
   output logic                               rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vrl_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [vrl_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [vrl_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import vrl_pkg::*;

   localparam int W = SPEED_WIDTH;

   cfg_type cfg;

   logic                in_valid_ff;
   req_kind_type        in_kind_ff;
   logic signed [W-1:0] in_tx_ff, in_ty_ff, in_tz_ff;

   logic signed [W-1:0] speed_x_ff, speed_y_ff, speed_z_ff;
   logic signed [W-1:0] speed_x_in, speed_y_in, speed_z_in;
   logic                stop_ff, stop_in;
   logic                out_valid_ff, out_valid_in;

   logic signed [W-1:0] cmd_x, cmd_y, cmd_z;
   logic                req_fire, fire;

   vrl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance the stage when the result slot is free or being drained
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_kind_ff <= req_kind_type'(req_tuser);
         in_tx_ff   <= req_tdata[W-1:0];
         in_ty_ff   <= req_tdata[2*W-1:W];
         in_tz_ff   <= req_tdata[3*W-1:2*W];
      end
   end

   vrl_axis #(.W(W), .CLAMP_EN(1'b1)) u_axis_x (
      .cur     (speed_x_ff),
      .target  (in_tx_ff),
      .step    (cfg.step_x),
      .soft_en (cfg.soft_en),
      .ratio   (cfg.ratio_eff),
      .next    (cmd_x)
   );

   // linear y is never clamped
   vrl_axis #(.W(W), .CLAMP_EN(1'b0)) u_axis_y (
      .cur     (speed_y_ff),
      .target  (in_ty_ff),
      .step    (cfg.step_y),
      .soft_en (cfg.soft_en),
      .ratio   (cfg.ratio_eff),
      .next    (cmd_y)
   );

   vrl_axis #(.W(W), .CLAMP_EN(1'b1)) u_axis_z (
      .cur     (speed_z_ff),
      .target  (in_tz_ff),
      .step    (cfg.step_z),
      .soft_en (cfg.soft_en),
      .ratio   (cfg.ratio_eff),
      .next    (cmd_z)
   );

   always_comb begin
      speed_x_in = speed_x_ff;
      speed_y_in = speed_y_ff;
      speed_z_in = speed_z_ff;
      stop_in    = stop_ff;
      case (in_kind_ff)
         REQ_COMMAND: begin
            if (stop_ff) begin
               speed_x_in = '0;
               speed_y_in = '0;
               speed_z_in = '0;
            end else begin
               speed_x_in = cmd_x;
               speed_y_in = cmd_y;
               speed_z_in = cmd_z;
            end
         end
         REQ_LOAD: begin
            if (!stop_ff) begin
               speed_x_in = in_tx_ff;
               speed_y_in = in_ty_ff;
               speed_z_in = in_tz_ff;
            end
         end
         REQ_STOP: begin
            stop_in    = 1'b1;
            speed_x_in = '0;
            speed_y_in = '0;
            speed_z_in = '0;
         end
         REQ_RELEASE: begin
            stop_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // the speed state doubles as the result register: it only moves on fire
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_x_ff   <= '0;
         speed_y_ff   <= '0;
         speed_z_ff   <= '0;
         stop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            speed_x_ff <= speed_x_in;
            speed_y_ff <= speed_y_in;
            speed_z_ff <= speed_z_in;
            stop_ff    <= stop_in;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'({speed_z_ff, speed_y_ff, speed_x_ff});
   assign rsp_tuser  = stop_ff;

   a_stop_forces_zero: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> (speed_x_ff == '0 && speed_y_ff == '0 && speed_z_ff == '0))
      else $error("speeds nonzero while stop latched");

   a_latch_stop: assert property (@(posedge clock) disable iff (reset)
      (fire && in_kind_ff == REQ_STOP) |=> (stop_ff && rsp_tvalid))
      else $error("stop transaction did not latch");

   a_release_holds: assert property (@(posedge clock) disable iff (reset)
      (fire && in_kind_ff == REQ_RELEASE) |=>
         (!stop_ff && $stable(speed_x_ff) && $stable(speed_y_ff) && $stable(speed_z_ff)))
      else $error("release changed speeds or kept stop");

   a_pending_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("pending transaction dropped");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !fire)
      else $error("result overwritten while stalled");

endmodule
